// File: sv/chha_pkg.sv
// Package for the calorimeter cell hit accumulator.
// Holds the shared types and constants; no dependencies.
package chha_pkg;
	localparam int MAX_CELLS_DEF = 63;
	localparam int ID_W = 14;
	localparam int DATA_W = 32;
	localparam int CNT_W = 6;
	localparam logic [17:0] MEV_SAT = 18'h3FFFF;

	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_REC = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	localparam logic FUNC_DEP = 1'b0;
	localparam logic FUNC_EOE = 1'b1;

	localparam logic REG_THR = 1'b0;
	localparam logic REG_MAXREC = 1'b1;

	typedef struct packed {
		logic func;
		logic bad;
		logic [ID_W-1:0] id;
		logic [DATA_W-1:0] energy;
		logic [DATA_W-1:0] tim;
	} item_t;
endpackage

// File: sv/chha_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module chha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 63,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/chha_front.sv
// Front end: accepts requests, checks bin ranges, forms the cell id and
// queues the classified item for the back end. Uses chha_pkg.
module chha_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic func,
	input logic signed [8:0] theta_index,
	input logic signed [8:0] phi_index,
	input logic [31:0] deposit_energy,
	input logic [31:0] hit_time,
	output logic busy,
	output chha_pkg::item_t head,
	output logic head_v,
	input logic pop
);
	import chha_pkg::*;

	item_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;
	item_t in_item;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign head = ent_q[rp_q];
	assign head_v = (cnt_q != 2'd0);

	always_comb begin
		in_item.func = func;
		// A negative bin has bit 8 set; bit 7 set means above 127.
		in_item.bad = (theta_index[8:7] != 2'b00) || (phi_index[8:7] != 2'b00);
		in_item.id = {theta_index[6:0], phi_index[6:0]};
		in_item.energy = deposit_energy;
		in_item.tim = hit_time;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: sv/chha_back.sv
// Back end: the cell table (parallel id match row plus energy, time and id
// memories), deposit merging and the end-of-event readout. Uses chha_pkg
// and chha_ram.
module chha_back #(
	parameter int MAX_CELLS = chha_pkg::MAX_CELLS_DEF
) (
	input logic clk,
	input logic arst_n,
	input chha_pkg::item_t head,
	input logic head_v,
	output logic pop,
	input logic [31:0] thr,
	input logic [5:0] maxrec,
	output logic strobe,
	output logic [1:0] kind,
	output logic accepted,
	output logic [13:0] cell_id,
	output logic [31:0] packed_word,
	output logic [31:0] cell_energy,
	output logic [31:0] earliest_time,
	output logic [5:0] record_count,
	output logic last
);
	import chha_pkg::*;

	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEP = 2'd1;
	localparam logic [1:0] ST_DUMP = 2'd2;

	logic [1:0] state_q;
	logic [CW-1:0] count_q;
	logic [ID_W-1:0] ids_q [MAX_CELLS];
	item_t item_s1;
	logic hit_s1;
	logic [AW-1:0] hidx_s1;
	logic [CW-1:0] rd_idx_q;
	logic v_s1;
	logic [CNT_W-1:0] ecnt_q;

	logic [MAX_CELLS-1:0] hitvec;
	logic any_hit;
	logic [AW-1:0] hidx;
	logic [AW-1:0] raddr, waddr;
	logic we;
	logic [DATA_W-1:0] wen_d, wtm_d, rd_en, rd_tm;
	logic [ID_W-1:0] rd_id;
	logic [DATA_W:0] sum;
	logic [DATA_W-1:0] sum_sat, tmin;
	logic full;
	logic [21:0] mev_raw;
	logic [17:0] mev;

	always_comb begin
		any_hit = 1'b0;
		hidx = '0;
		for (int i = 0; i < MAX_CELLS; i++) begin
			hitvec[i] = (CW'(i) < count_q) && (ids_q[i] == head.id);
		end
		for (int i = MAX_CELLS - 1; i >= 0; i--) begin
			if (hitvec[i]) begin
				any_hit = 1'b1;
				hidx = AW'(i);
			end
		end
	end

	assign full = (count_q == CW'(MAX_CELLS));
	assign sum = {1'b0, rd_en} + {1'b0, item_s1.energy};
	assign sum_sat = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
	assign tmin = (item_s1.tim < rd_tm) ? item_s1.tim : rd_tm;
	assign mev_raw = rd_en[31:10];
	assign mev = (mev_raw > {4'b0, MEV_SAT}) ? MEV_SAT : mev_raw[17:0];

	always_comb begin
		pop = (state_q == ST_IDLE) && head_v;
		raddr = '0;
		case (state_q)
			ST_IDLE: raddr = any_hit ? hidx : '0;
			ST_DUMP: raddr = rd_idx_q[AW-1:0];
			default: raddr = '0;
		endcase
		we = (state_q == ST_DEP) && (hit_s1 || !full);
		waddr = hit_s1 ? hidx_s1 : count_q[AW-1:0];
		wen_d = hit_s1 ? sum_sat : item_s1.energy;
		wtm_d = hit_s1 ? tmin : item_s1.tim;
	end

	chha_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CELLS), .AW(AW)) u_en (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wen_d), .raddr(raddr), .rdata(rd_en)
	);
	chha_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CELLS), .AW(AW)) u_tm (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wtm_d), .raddr(raddr), .rdata(rd_tm)
	);
	chha_ram #(.WIDTH(ID_W), .DEPTH(MAX_CELLS), .AW(AW)) u_id (
		.clk(clk), .we(we), .waddr(waddr), .wdata(item_s1.id), .raddr(raddr),
		.rdata(rd_id)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && head_v) begin
			item_s1 <= head;
			hit_s1 <= any_hit;
			hidx_s1 <= hidx;
		end
		if (we && !hit_s1) begin
			ids_q[count_q[AW-1:0]] <= item_s1.id;
		end
		kind <= KIND_ACK;
		accepted <= 1'b0;
		cell_id <= '0;
		packed_word <= '0;
		cell_energy <= '0;
		earliest_time <= '0;
		record_count <= '0;
		last <= 1'b1;
		case (state_q)
			ST_DEP: begin
				cell_id <= item_s1.id;
				if (hit_s1) begin
					accepted <= 1'b1;
					cell_energy <= sum_sat;
					earliest_time <= tmin;
				end else if (!full) begin
					accepted <= 1'b1;
					cell_energy <= item_s1.energy;
					earliest_time <= item_s1.tim;
				end
			end
			ST_DUMP: begin
				if (v_s1) begin
					kind <= KIND_REC;
					last <= 1'b0;
					cell_id <= rd_id;
					packed_word <= {rd_id, mev};
					cell_energy <= rd_en;
					earliest_time <= rd_tm;
					record_count <= ecnt_q + 1'b1;
				end else begin
					kind <= KIND_END;
					record_count <= ecnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_idx_q <= '0;
			v_s1 <= 1'b0;
			ecnt_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head_v) begin
						if (head.func == FUNC_EOE) begin
							state_q <= ST_DUMP;
							rd_idx_q <= '0;
							v_s1 <= 1'b0;
							ecnt_q <= '0;
						end else if (head.bad) begin
							strobe <= 1'b1;
						end else begin
							state_q <= ST_DEP;
						end
					end
				end
				ST_DEP: begin
					strobe <= 1'b1;
					if (!hit_s1 && !full) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_DUMP: begin
					// Reads are issued one per cycle; the entry read in the
					// previous cycle is judged against threshold and limit.
					v_s1 <= 1'b0;
					if (rd_idx_q < count_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						v_s1 <= 1'b1;
					end
					if (v_s1) begin
						if (rd_en > thr && ecnt_q < maxrec) begin
							strobe <= 1'b1;
							ecnt_q <= ecnt_q + 1'b1;
						end
					end else if (rd_idx_q >= count_q) begin
						strobe <= 1'b1;
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: sv/calorimeter_cell_hit_accumulator_top.sv
// Top level of the calorimeter cell hit accumulator: configuration
// registers on an APB-style port, front end and back end. Uses chha_pkg,
// chha_front and chha_back.
//
// Usage: a request is taken at a rising edge where start is high and busy
// is low. func selects a deposit or an end of event. Each result appears
// for exactly one cycle with strobe high; the receiver cannot stall it.
// With an idle back end, a deposit is popped and matched in the id row,
// then the energy and time memories are read-modify-written and the
// acknowledge, accepted for a merge or append, is held in the output
// register. A rejected bin skips the memory step and is acknowledged from
// the pop. An end of event is popped, then the table is walked one entry a
// cycle through the memory read port, emitting the cell records that pass
// threshold and record limit, and the end marker.
// A two-entry queue sits between front and back, so busy rises only when
// both entries wait. Reset empties the queue and the table and sets the
// threshold to 1 and the record limit to 63. Write configuration only
// while idle.
module calorimeter_cell_hit_accumulator_top #(
	parameter int MAX_CELLS = chha_pkg::MAX_CELLS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic start,
	output logic busy,
	input logic func,
	input logic signed [8:0] theta_index,
	input logic signed [8:0] phi_index,
	input logic [31:0] deposit_energy,
	input logic [31:0] hit_time,
	output logic strobe,
	output logic [1:0] kind,
	output logic accepted,
	output logic [13:0] cell_id,
	output logic [31:0] packed_word,
	output logic [31:0] cell_energy,
	output logic [31:0] earliest_time,
	output logic [5:0] record_count,
	output logic last
);
	import chha_pkg::*;

	logic [31:0] thr_q;
	logic [5:0] maxrec_q;
	item_t head;
	logic head_v, pop;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_MAXREC) ? {26'b0, maxrec_q} : thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 32'd1;
			maxrec_q <= 6'd63;
		end else if (wr) begin
			case (paddr[2])
				REG_THR: thr_q <= pwdata;
				REG_MAXREC: maxrec_q <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	chha_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.theta_index(theta_index), .phi_index(phi_index),
		.deposit_energy(deposit_energy), .hit_time(hit_time), .busy(busy),
		.head(head), .head_v(head_v), .pop(pop)
	);

	chha_back #(.MAX_CELLS(MAX_CELLS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_v(head_v), .pop(pop),
		.thr(thr_q), .maxrec(maxrec_q), .strobe(strobe), .kind(kind),
		.accepted(accepted), .cell_id(cell_id), .packed_word(packed_word),
		.cell_energy(cell_energy), .earliest_time(earliest_time),
		.record_count(record_count), .last(last)
	);
endmodule

// File: sv/chha_chk.sv
// Port-level checker for the cell hit accumulator, bound to the top level.
// Uses chha_pkg.
module chha_chk (
	input logic clk,
	input logic arst_n,
	input logic pready,
	input logic strobe,
	input logic [1:0] kind,
	input logic accepted,
	input logic [31:0] packed_word,
	input logic [5:0] record_count,
	input logic last
);
	import chha_pkg::*;

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (kind == KIND_ACK || kind == KIND_REC || kind == KIND_END))
		else $error("bad result kind");
	a_rec: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_REC) |-> (!last && !accepted && record_count != 6'd0))
		else $error("bad cell record");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_END) |-> (last && !accepted && packed_word == 32'd0))
		else $error("bad end marker");
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_ACK) |-> (last && packed_word == 32'd0))
		else $error("bad acknowledge");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind calorimeter_cell_hit_accumulator_top chha_chk u_chk (
	.clk(clk), .arst_n(arst_n), .pready(pready), .strobe(strobe), .kind(kind),
	.accepted(accepted), .packed_word(packed_word), .record_count(record_count),
	.last(last)
);
